@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL; they assume clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/hds_pkg.sv @@
// Shared types and constants of the horizontal diffusion stencil.
package hds_pkg;

    localparam int SAMPLE_W  = 48;
    localparam int COEF_W    = 18;
    localparam int TAU_W     = 17;
    localparam int POS_W     = 10;
    localparam int KIND_W    = 3;
    localparam int ILEN_W    = 10;
    localparam int BW_W      = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 10;
    localparam int FRAC_SH   = 18;              // tau/4 in Q.18
    localparam int LAP_W     = SAMPLE_W + 3;    // exact left - 2x + right
    localparam int MAG_W     = SAMPLE_W + 1;    // |lap| < 2^49
    localparam int LO_W      = FRAC_SH;
    localparam int HI_W      = MAG_W - LO_W;
    localparam int HIP_W     = HI_W + TAU_W;
    localparam int LOP_W     = LO_W + TAU_W;
    localparam int SUM_W     = SAMPLE_W + 2;

    localparam logic [ILEN_W-1:0] ILEN_RESET = ILEN_W'(64);
    localparam logic [BW_W-1:0]   BW_RESET   = BW_W'(2);

    typedef enum logic [KIND_W-1:0] {
        KIND_VELOCITY = 3'd0,
        KIND_DENSITY  = 3'd1,
        KIND_VAPOUR   = 3'd2,
        KIND_CLOUD    = 3'd3,
        KIND_RAIN     = 3'd4
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INTERIOR_LENGTH = 2'd0,
        CFG_BOUNDARY_WIDTH  = 2'd1,
        CFG_MOIST_ENABLED   = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [ILEN_W-1:0] interior_length;
        logic [BW_W-1:0]   boundary_width;
        logic              moist_enabled;
    } hds_cfg_t;

    // One interior point leaving the window stage.
    typedef struct packed {
        logic                       diffuse;
        logic signed [SAMPLE_W-1:0] left_val;
        logic signed [SAMPLE_W-1:0] center_val;
        logic signed [SAMPLE_W-1:0] right_val;
        logic [TAU_W-1:0]           tau;
        logic [POS_W-1:0]           position;
        logic [KIND_W-1:0]          kind;
        logic                       last;
    } hds_stage_t;

    typedef struct packed {
        logic pos_zero;
        logic window_zero;
    } hds_win_status_t;

endpackage

@@ hdl/hds_window.sv @@
// Sample window, row position counter and interior-point selection.
module hds_window
    import hds_pkg::*;
#(
    parameter int MAX_ROW = 1024
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  logic                       in_valid,
    input  logic [KIND_W-1:0]          kind,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic signed [COEF_W-1:0]   coefficient,
    input  logic                       row_last,
    input  hds_cfg_t                   cfg,
    output logic                       stage_valid,
    output hds_stage_t                 stage,
    output hds_win_status_t            status
);

    localparam int PW = $clog2(MAX_ROW);
    localparam int CW = ((PW > ILEN_W + 1) ? PW : ILEN_W + 1) + 1;
    localparam logic [PW-1:0] POS_STOP = PW'(MAX_ROW - 1);

    logic signed [SAMPLE_W-1:0] left_reg, left_next;
    logic signed [SAMPLE_W-1:0] center_reg, center_next;
    logic [PW-1:0]              pos_reg, pos_next;
    logic                       stage_valid_reg, stage_valid_next;
    hds_stage_t                 stage_reg, stage_next;

    logic          accept;
    logic          kind_ok;
    logic          in_range;
    logic          interior;
    logic          emit;
    logic [CW-1:0] idx;
    logic [CW-1:0] last_pt;
    logic [CW-1:0] end_pt;
    logic [CW-1:0] rel;

    assign accept = advance && in_valid;

    always_comb
    begin
        kind_ok  = (kind <= KIND_RAIN) &&
                   (!(kind inside {[KIND_VAPOUR:KIND_RAIN]}) || cfg.moist_enabled);
        in_range = (pos_reg != '0) && (pos_reg < POS_STOP);
        idx      = CW'(pos_reg) - CW'(1);
        last_pt  = CW'(cfg.interior_length) + CW'(cfg.boundary_width);
        if (kind == KIND_VELOCITY)
        begin
            interior = (idx >= CW'(cfg.boundary_width)) && (idx <= last_pt);
            end_pt   = last_pt;
        end
        else
        begin
            interior = (idx >= CW'(cfg.boundary_width)) && (idx + CW'(1) <= last_pt);
            end_pt   = last_pt - CW'(1);
        end
        rel  = idx - CW'(cfg.boundary_width);
        emit = kind_ok && in_range && interior;
    end

    // window and counter move only on kept items
    always_comb
    begin
        left_next   = left_reg;
        center_next = center_reg;
        pos_next    = pos_reg;
        if (accept && kind_ok)
        begin
            if (row_last)
            begin
                left_next   = '0;
                center_next = '0;
                pos_next    = '0;
            end
            else
            begin
                left_next   = center_reg;
                center_next = sample;
                if (pos_reg < POS_STOP)
                    pos_next = pos_reg + PW'(1);
            end
        end
    end

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        stage_next       = stage_reg;
        if (advance)
        begin
            stage_valid_next      = in_valid && emit;
            stage_next.diffuse    = !coefficient[COEF_W-1] && (coefficient[TAU_W-1:0] != '0);
            stage_next.left_val   = left_reg;
            stage_next.center_val = center_reg;
            stage_next.right_val  = sample;
            stage_next.tau        = coefficient[TAU_W-1:0];
            stage_next.position   = rel[POS_W-1:0];
            stage_next.kind       = kind;
            stage_next.last       = (idx == end_pt);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg        <= '0;
            center_reg      <= '0;
            pos_reg         <= '0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            left_reg        <= left_next;
            center_reg      <= center_next;
            pos_reg         <= pos_next;
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign stage_valid        = stage_valid_reg;
    assign stage              = stage_reg;
    assign status.pos_zero    = (pos_reg == '0);
    assign status.window_zero = (left_reg == '0) && (center_reg == '0);

endmodule

@@ hdl/hds_datapath.sv @@
// Laplacian, split coefficient multiply, rounding and saturation stages.
module hds_datapath
    import hds_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  logic                       stage_valid,
    input  hds_stage_t                 stage,
    output logic                       out_valid,
    output logic signed [SAMPLE_W-1:0] value_out,
    output logic [POS_W-1:0]           position,
    output logic [KIND_W-1:0]          kind_out,
    output logic                       last_of_row
);

    typedef struct packed {
        logic                       diffuse;
        logic                       neg;
        logic [HI_W-1:0]            mag_hi;
        logic [LO_W-1:0]            mag_lo;
        logic [TAU_W-1:0]           tau;
        logic signed [SAMPLE_W-1:0] center_val;
        logic [POS_W-1:0]           position;
        logic [KIND_W-1:0]          kind;
        logic                       last;
    } lap_t;

    typedef struct packed {
        logic                       diffuse;
        logic                       neg;
        logic [HIP_W-1:0]           prod_hi;
        logic [LOP_W-1:0]           prod_lo;
        logic signed [SAMPLE_W-1:0] center_val;
        logic [POS_W-1:0]           position;
        logic [KIND_W-1:0]          kind;
        logic                       last;
    } prod_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic [POS_W-1:0]           position;
        logic [KIND_W-1:0]          kind;
        logic                       last;
    } res_t;

    localparam logic [LOP_W-1:0] HALF_LSB = LOP_W'(1) << (FRAC_SH - 1);

    logic  s1_valid_reg, s2_valid_reg, out_valid_reg;
    lap_t  s1_reg, s1_next;
    prod_t s2_reg, s2_next;
    res_t  out_reg, out_next;

    logic signed [LAP_W-1:0] lap;
    logic [LAP_W-1:0]        mag_full;
    logic [MAG_W-1:0]        mag;
    logic [MAG_W-1:0]        delta;
    logic signed [SUM_W-1:0] sum;

    // stage 1: exact laplacian and its magnitude
    always_comb
    begin
        lap = LAP_W'($signed(stage.left_val)) - (LAP_W'($signed(stage.center_val)) <<< 1)
              + LAP_W'($signed(stage.right_val));
        mag_full = lap[LAP_W-1] ? (~lap + LAP_W'(1)) : lap;
        mag      = mag_full[MAG_W-1:0];
        s1_next.diffuse    = stage.diffuse;
        s1_next.neg        = lap[LAP_W-1];
        s1_next.mag_hi     = mag[MAG_W-1:LO_W];
        s1_next.mag_lo     = mag[LO_W-1:0];
        s1_next.tau        = stage.tau;
        s1_next.center_val = stage.center_val;
        s1_next.position   = stage.position;
        s1_next.kind       = stage.kind;
        s1_next.last       = stage.last;
    end

    // stage 2: two narrow partial products
    always_comb
    begin
        s2_next.diffuse    = s1_reg.diffuse;
        s2_next.neg        = s1_reg.neg;
        s2_next.prod_hi    = HIP_W'(s1_reg.mag_hi) * HIP_W'(s1_reg.tau);
        s2_next.prod_lo    = LOP_W'(s1_reg.mag_lo) * LOP_W'(s1_reg.tau);
        s2_next.center_val = s1_reg.center_val;
        s2_next.position   = s1_reg.position;
        s2_next.kind       = s1_reg.kind;
        s2_next.last       = s1_reg.last;
    end

    // stage 3: round half away from zero, add, saturate
    always_comb
    begin
        delta = MAG_W'(s2_reg.prod_hi) + MAG_W'((s2_reg.prod_lo + HALF_LSB) >> FRAC_SH);
        if (s2_reg.neg)
            sum = SUM_W'($signed(s2_reg.center_val)) - $signed({1'b0, delta});
        else
            sum = SUM_W'($signed(s2_reg.center_val)) + $signed({1'b0, delta});
        out_next.position = s2_reg.position;
        out_next.kind     = s2_reg.kind;
        out_next.last     = s2_reg.last;
        if (!s2_reg.diffuse)
            out_next.value = s2_reg.center_val;
        else if (sum[SUM_W-1:SAMPLE_W-1] == '0 || sum[SUM_W-1:SAMPLE_W-1] == '1)
            out_next.value = sum[SAMPLE_W-1:0];
        else if (sum[SUM_W-1])
            out_next.value = {1'b1, {(SAMPLE_W-1){1'b0}}};
        else
            out_next.value = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= stage_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_reg  <= s1_next;
            s2_reg  <= s2_next;
            out_reg <= out_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign value_out   = out_reg.value;
    assign position    = out_reg.position;
    assign kind_out    = out_reg.kind;
    assign last_of_row = out_reg.last;

endmodule

@@ hdl/horizontal_diffusion_stencil.sv @@
// Top level of the three-point horizontal diffusion stencil.
// Input channel (in_valid/in_ready): one grid sample per transfer, left to
// right along a row, with its field kind, the level coefficient and a
// row_last mark on the final sample of the row.
// Output channel (out_valid/out_ready): one diffused interior point per
// transfer with its interior index, kind and a last_of_row mark. Boundary
// points, dropped kinds and samples past the row's end give no transfer.
// Config channel (cfg_valid/cfg_ready): always ready; index 0 interior
// length, 1 boundary width, 2 moisture enable. Write only while idle.
// A point's result follows the transfer of the sample to its right
// through the four-register pipeline (window, laplacian, multiply,
// round/saturate). Throughput: one sample per cycle; the pipeline
// moves as one while the output register is empty or being taken.
// Receiver stall: the whole pipeline holds and in_ready drops, so the
// input side is held too; no result is lost.
// Reset: window and position clear to zero, registers load 64, 2 and 0,
// and the pipeline empties.
module horizontal_diffusion_stencil
    import hds_pkg::*;
#(
    parameter int MAX_ROW = 1024
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [KIND_W-1:0]            kind,
    input  logic signed [SAMPLE_W-1:0]   sample,
    input  logic signed [COEF_W-1:0]     coefficient,
    input  logic                         row_last,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [SAMPLE_W-1:0]   value_out,
    output logic [POS_W-1:0]             position,
    output logic [KIND_W-1:0]            kind_out,
    output logic                         last_of_row,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data
);

    hds_cfg_t        cfg_reg, cfg_next;
    hds_stage_t      stage;
    hds_win_status_t win_status;
    logic            stage_valid;
    logic            advance;

    // pipeline moves when the output register is free or drains this cycle
    assign advance   = !out_valid || out_ready;
    assign in_ready  = advance;
    assign cfg_ready = 1'b1;

    // configuration registers; unmapped indexes are ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_INTERIOR_LENGTH: cfg_next.interior_length = cfg_data[ILEN_W-1:0];
                CFG_BOUNDARY_WIDTH:  cfg_next.boundary_width  = cfg_data[BW_W-1:0];
                CFG_MOIST_ENABLED:   cfg_next.moist_enabled   = cfg_data[0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.interior_length <= ILEN_RESET;
            cfg_reg.boundary_width  <= BW_RESET;
            cfg_reg.moist_enabled   <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // window, position counter and point selection
    hds_window #(
        .MAX_ROW (MAX_ROW)
    ) u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .in_valid    (in_valid),
        .kind        (kind),
        .sample      (sample),
        .coefficient (coefficient),
        .row_last    (row_last),
        .cfg         (cfg_reg),
        .stage_valid (stage_valid),
        .stage       (stage),
        .status      (win_status)
    );

    // arithmetic stages and output register
    hds_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage       (stage),
        .out_valid   (out_valid),
        .value_out   (value_out),
        .position    (position),
        .kind_out    (kind_out),
        .last_of_row (last_of_row)
    );

`include "assert_macros.svh"

    // a kept row end clears the window and restarts the count
    `ASSERT_NEXT(a_row_end_clears, in_valid && in_ready && row_last && (kind <= KIND_DENSITY), win_status.pos_zero && win_status.window_zero, "row end did not clear window")

    // an empty output register never blocks the input
    `ASSERT_IMP(a_empty_ready, !out_valid, in_ready, "input blocked with empty output")

    // only defined kinds ever reach the output
    `ASSERT_IMP(a_kind_legal, out_valid, kind_out <= KIND_RAIN, "undefined kind on output")

endmodule
